// ----- src/lru_chunk_cache_lookup_core_macros.svh -----
// ----------------------------------------------------------------------------
// LRU chunk cache lookup core: assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef LRU_CHUNK_CACHE_LOOKUP_CORE_MACROS_SVH
`define LRU_CHUNK_CACHE_LOOKUP_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCCL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lccl: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define LCCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lccl: next-cycle property failed");

`endif

// ----- src/lccl_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU chunk cache lookup package
// Sizes, stream field positions and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lccl_pkg;

  // Chunk size in bytes, a power of two, and number of cache slots.
  localparam int CHUNK_BYTES = 65536;
  localparam int CACHE_SLOTS = 16;

  localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int ROOM_W      = CHUNK_SHIFT + 1;
  localparam int SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int AGE_W       = SLOT_W;
  localparam int AGE_OLDEST  = CACHE_SLOTS - 1;

  // Field widths.
  localparam int OFF_W   = 40;
  localparam int WANT_W  = 32;
  localparam int CHUNK_W = 24;
  localparam int TAG_W   = 24;
  localparam int INOFF_W = 16;
  localparam int SPAN_W  = 17;
  localparam int SLOTO_W = 4;

  // Input tdata layout.
  localparam int IN_OFF_LSB  = 0;
  localparam int IN_WANT_LSB = IN_OFF_LSB + OFF_W;
  localparam int IN_TDATA_W  = 72;

  // Output tdata layout.
  localparam int OUT_CHUNK_LSB = 0;
  localparam int OUT_INOFF_LSB = OUT_CHUNK_LSB + CHUNK_W;
  localparam int OUT_SPAN_LSB  = OUT_INOFF_LSB + INOFF_W;
  localparam int OUT_HIT_BIT   = OUT_SPAN_LSB + SPAN_W;
  localparam int OUT_SLOT_LSB  = OUT_HIT_BIT + 1;
  localparam int OUT_EVICT_BIT = OUT_SLOT_LSB + SLOTO_W;
  localparam int OUT_VIC_LSB   = OUT_EVICT_BIT + 1;
  localparam int OUT_USED_W    = OUT_VIC_LSB + TAG_W;
  localparam int OUT_TDATA_W   = 88;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the accepted request and split it
    logic update;   // run the lookup, update the tag store, load the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_stall;  // result register holds a result that is not being taken
  } dp_sts_t;

endpackage

// ----- src/lccl_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU chunk cache lookup controller
// Sequences request capture and the tag store update, one request at a time.
// ----------------------------------------------------------------------------
module lccl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lccl_pkg::dp_sts_t sts,
  output lccl_pkg::dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.update  = (state_r == S_LOOKUP) && !sts.out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (cmd.update) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/lccl_dp.sv -----
// ----------------------------------------------------------------------------
// LRU chunk cache lookup datapath
// Offset split, fully associative tag store with LRU ages, result register.
// ----------------------------------------------------------------------------
module lccl_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [lccl_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lccl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  lccl_pkg::dp_cmd_t                  cmd,
  output lccl_pkg::dp_sts_t                  sts
);

  localparam int N = lccl_pkg::CACHE_SLOTS;

  // Split of the incoming request.
  logic [lccl_pkg::OFF_W-1:0]       in_off;
  logic [lccl_pkg::WANT_W-1:0]      in_want;
  logic [lccl_pkg::CHUNK_SHIFT-1:0] in_inoff;
  logic [lccl_pkg::ROOM_W-1:0]      in_room;
  logic [lccl_pkg::ROOM_W-1:0]      in_span;
  logic [lccl_pkg::CHUNK_W-1:0]     in_chunk;

  assign in_off   = in_tdata[lccl_pkg::IN_OFF_LSB +: lccl_pkg::OFF_W];
  assign in_want  = in_tdata[lccl_pkg::IN_WANT_LSB +: lccl_pkg::WANT_W];
  assign in_chunk = lccl_pkg::CHUNK_W'(in_off >> lccl_pkg::CHUNK_SHIFT);
  assign in_inoff = in_off[lccl_pkg::CHUNK_SHIFT-1:0];
  assign in_room  = lccl_pkg::ROOM_W'(lccl_pkg::CHUNK_BYTES) - {1'b0, in_inoff};
  assign in_span  = (in_want < lccl_pkg::WANT_W'(in_room)) ?
                    lccl_pkg::ROOM_W'(in_want) : in_room;

  logic [lccl_pkg::CHUNK_W-1:0]     req_chunk_r;
  logic [lccl_pkg::CHUNK_SHIFT-1:0] req_inoff_r;
  logic [lccl_pkg::ROOM_W-1:0]      req_span_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_chunk_r <= in_chunk;
      req_inoff_r <= in_inoff;
      req_span_r  <= in_span;
    end
  end

  // Tag store.
  logic [N-1:0]                   valid_r, valid_nxt;
  logic [lccl_pkg::AGE_W-1:0]     age_r   [N];
  logic [lccl_pkg::AGE_W-1:0]     age_nxt [N];
  logic [lccl_pkg::TAG_W-1:0]     tag_r   [N];

  logic [N-1:0]               hit_oh, free_oh, old_oh, sel_oh;
  logic [lccl_pkg::SLOT_W-1:0] hit_idx, free_idx, old_idx, sel_idx;
  logic                        hit, any_free, evict;
  logic [lccl_pkg::AGE_W-1:0]  hit_age, limit;
  logic [lccl_pkg::TAG_W-1:0]  victim;
  logic                        f_hit, f_free, f_old;

  always_comb begin
    hit_oh   = '0;
    free_oh  = '0;
    old_oh   = '0;
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    f_hit    = 1'b0;
    f_free   = 1'b0;
    f_old    = 1'b0;
    hit_age  = '0;
    victim   = '0;
    for (int i = 0; i < N; i++) begin
      if (!f_hit && valid_r[i] && (tag_r[i] == req_chunk_r)) begin
        f_hit     = 1'b1;
        hit_oh[i] = 1'b1;
        hit_idx   = lccl_pkg::SLOT_W'(i);
      end
      if (!f_free && !valid_r[i]) begin
        f_free     = 1'b1;
        free_oh[i] = 1'b1;
        free_idx   = lccl_pkg::SLOT_W'(i);
      end
      // With every slot valid the ages are distinct, so the oldest has the top age.
      if (!f_old && (age_r[i] == lccl_pkg::AGE_W'(lccl_pkg::AGE_OLDEST))) begin
        f_old     = 1'b1;
        old_oh[i] = 1'b1;
        old_idx   = lccl_pkg::SLOT_W'(i);
      end
    end
    for (int i = 0; i < N; i++) begin
      if (hit_oh[i]) hit_age = hit_age | age_r[i];
      if (old_oh[i]) victim  = victim | tag_r[i];
    end
  end

  assign hit      = f_hit;
  assign any_free = f_free;
  assign evict    = !hit && !any_free;
  assign sel_oh   = hit ? hit_oh : (any_free ? free_oh : old_oh);
  assign sel_idx  = hit ? hit_idx : (any_free ? free_idx : old_idx);
  assign limit    = hit ? hit_age : lccl_pkg::AGE_W'(lccl_pkg::AGE_OLDEST);

  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < N; i++) begin
      age_nxt[i] = age_r[i];
      // On a fill into a free slot every valid entry ages by one.
      if (valid_r[i] && ((!hit && any_free) || (age_r[i] < limit))) begin
        age_nxt[i] = age_r[i] + lccl_pkg::AGE_W'(1);
      end
      if (sel_oh[i]) begin
        age_nxt[i]   = '0;
        valid_nxt[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < N; i++) begin
        age_r[i] <= '0;
      end
    end else if (cmd.update) begin
      valid_r <= valid_nxt;
      for (int i = 0; i < N; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (cmd.update && !hit && sel_oh[i]) begin
        tag_r[i] <= req_chunk_r;
      end
    end
  end

  // Result register.
  logic                          out_valid_r;
  logic [lccl_pkg::OUT_USED_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data_r <= {(evict ? victim : lccl_pkg::TAG_W'(0)),
                     evict,
                     lccl_pkg::SLOTO_W'(sel_idx),
                     hit,
                     lccl_pkg::SPAN_W'(req_span_r),
                     lccl_pkg::INOFF_W'(req_inoff_r),
                     req_chunk_r};
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = lccl_pkg::OUT_TDATA_W'(out_data_r);
  assign sts.out_stall = out_valid_r && !out_tready;

endmodule

// ----- src/lru_chunk_cache_lookup_core.sv -----
// ----------------------------------------------------------------------------
// LRU chunk cache lookup core
// Splits a byte offset into chunk number and in-chunk offset, clamps the span
// to the chunk end, and looks the chunk up in a fully associative LRU tag store.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                          Transaction
//   in_*      slave      in_tvalid/in_tready/in_tdata    one chunk access
//   out_*     master     out_tvalid/out_tready/out_tdata one lookup result
//
// Each request is captured and split when it is accepted in S_IDLE; the
// parallel tag compare, LRU age update and result register load follow in S_LOOKUP. The
// lookup waits while the result register still holds a result that has
// not been taken, and a new request is taken only once the last one has left S_LOOKUP.
// A new request is accepted while an older result waits at the output.
// Reset is synchronous and active low; it clears the slot valid bits and ages
// at once, with no sweep over the tag store.
//
// The valid slots always hold the distinct ages zero up to count minus one,
// with zero the newest. A hit makes the entry newest and ages the younger
// ones; a miss fills the lowest free slot, or once all slots are valid
// replaces the slot of the top age and reports its tag as the victim.
module lru_chunk_cache_lookup_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata, lowest bit up: byte_offset[39:0], bytes_wanted[71:40]
  input  logic [lccl_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata, lowest bit up: chunk_number[23:0], offset_in_chunk[39:24],
  // span_bytes[56:40], hit[57], slot[61:58], evicted[62],
  // victim_chunk[86:63], zero pad[87]
  output logic [lccl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  lccl_pkg::dp_cmd_t cmd;
  lccl_pkg::dp_sts_t sts;

  // The controller decides when a request is taken and when it is looked up.
  lccl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the request, the tag store and the result register.
  lccl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- src/lccl_chk.sv -----
// ----------------------------------------------------------------------------
// LRU chunk cache lookup checker
// Port-level properties of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
`include "lru_chunk_cache_lookup_core_macros.svh"

module lccl_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lccl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                       in_acc;
  logic                       out_stall;
  logic                       evicted;
  logic                       hit;
  logic [lccl_pkg::TAG_W-1:0] victim;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign evicted   = out_tdata[lccl_pkg::OUT_EVICT_BIT];
  assign hit       = out_tdata[lccl_pkg::OUT_HIT_BIT];
  assign victim    = out_tdata[lccl_pkg::OUT_VIC_LSB +: lccl_pkg::TAG_W];

  `LCCL_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid)
  `LCCL_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_tdata))
  `LCCL_ASSERT_SAME(a_evict_miss, out_tvalid && evicted, !hit)
  `LCCL_ASSERT_SAME(a_victim_zero, out_tvalid && !evicted, victim == '0)
  `LCCL_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_tready)

endmodule

bind lru_chunk_cache_lookup_core lccl_chk u_chk (.*);
